// ===== rtl/btc_io_pkg.sv =====
// Types, flag bit positions and the one-step datapath function for the block
// transfer / compare / io step unit. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package btc_io_pkg;

  // flag register bit positions
  localparam int unsigned FlS  = 7;
  localparam int unsigned FlZ  = 6;
  localparam int unsigned Fl5  = 5;
  localparam int unsigned FlH  = 4;
  localparam int unsigned Fl3  = 3;
  localparam int unsigned FlPv = 2;
  localparam int unsigned FlN  = 1;
  localparam int unsigned FlC  = 0;

  // instruction class, low two bits of the request type
  typedef enum logic [1:0] {
    OP_LD  = 2'd0,
    OP_CP  = 2'd1,
    OP_IN  = 2'd2,
    OP_OUT = 2'd3
  } op_t;

  // write request kind
  typedef enum logic [1:0] {
    WK_NONE = 2'd0,
    WK_MEM  = 2'd1,
    WK_IO   = 2'd2
  } wkind_t;

  // one input beat
  typedef struct packed {
    logic [3:0]  req_type;
    logic [7:0]  acc;
    logic [7:0]  flags_in;
    logic [15:0] count_bc;
    logic [15:0] dest_de;
    logic [15:0] src_hl;
    logic [7:0]  data_byte;
    logic [15:0] pc_in;
    logic [15:0] memptr_in;
  } step_in_t;

  // one result beat
  typedef struct packed {
    logic [7:0]  flags_out;
    logic [15:0] count_bc_out;
    logic [15:0] dest_de_out;
    logic [15:0] src_hl_out;
    logic [15:0] memptr_out;
    logic [15:0] pc_out;
    wkind_t      write_kind;
    logic [15:0] write_address;
    logic [7:0]  write_data;
    logic        repeat_flag;
  } step_out_t;

  // one iteration of a block instruction
  function automatic step_out_t block_step(input step_in_t si);
    step_out_t   so;
    op_t         op;
    logic        dec;
    logic        rep;
    logic [15:0] step16;
    logic [7:0]  step8;
    logic [15:0] bc_n;
    logic [15:0] hl_n;
    logic [7:0]  n_ld;
    logic [7:0]  r_cp;
    logic        h_cp;
    logic [7:0]  n_cp;
    logic [7:0]  b_n;
    logic [8:0]  k_io;
    logic        again;
    op     = op_t'(si.req_type[1:0]);
    dec    = si.req_type[2];
    rep    = si.req_type[3];
    step16 = dec ? 16'hFFFF : 16'h0001;
    step8  = step16[7:0];
    hl_n   = si.src_hl + step16;
    b_n    = si.count_bc[15:8] - 8'd1;
    n_ld   = si.data_byte + si.acc;
    r_cp   = si.acc - si.data_byte;
    h_cp   = si.acc[3:0] < si.data_byte[3:0];
    n_cp   = r_cp - {7'd0, h_cp};
    k_io   = '0;
    bc_n   = si.count_bc - 16'd1;

    so               = '0;
    so.dest_de_out   = si.dest_de;
    so.src_hl_out    = hl_n;
    so.memptr_out    = si.memptr_in;
    so.pc_out        = si.pc_in;
    so.write_kind    = WK_NONE;
    again            = 1'b0;

    unique case (op)
      OP_LD: begin
        so.count_bc_out  = bc_n;
        so.dest_de_out   = si.dest_de + step16;
        so.write_kind    = WK_MEM;
        so.write_address = si.dest_de;
        so.write_data    = si.data_byte;
        so.flags_out     = {si.flags_in[FlS], si.flags_in[FlZ], n_ld[1], 1'b0,
                            n_ld[3], (bc_n != 16'd0), 1'b0, si.flags_in[FlC]};
        again            = bc_n != 16'd0;
      end
      OP_CP: begin
        so.count_bc_out  = bc_n;
        so.memptr_out    = si.memptr_in + step16;
        so.flags_out     = {r_cp[7], (r_cp == 8'd0), n_cp[1], h_cp,
                            n_cp[3], (bc_n != 16'd0), 1'b1, si.flags_in[FlC]};
        again            = (bc_n != 16'd0) && (r_cp != 8'd0);
      end
      OP_IN: begin
        so.count_bc_out  = {b_n, si.count_bc[7:0]};
        so.memptr_out    = si.count_bc + step16;
        so.write_kind    = WK_MEM;
        so.write_address = si.src_hl;
        so.write_data    = si.data_byte;
        k_io             = {1'b0, si.data_byte} + {1'b0, si.count_bc[7:0] + step8};
        again            = b_n != 8'd0;
      end
      OP_OUT: begin
        so.count_bc_out  = {b_n, si.count_bc[7:0]};
        so.memptr_out    = {b_n, si.count_bc[7:0]} + step16;
        so.write_kind    = WK_IO;
        so.write_address = {b_n, si.count_bc[7:0]};
        so.write_data    = si.data_byte;
        k_io             = {1'b0, si.data_byte} + {1'b0, hl_n[7:0]};
        again            = b_n != 8'd0;
      end
      default: begin
        so.count_bc_out = bc_n;
      end
    endcase

    // io flags share one layout
    if (op == OP_IN || op == OP_OUT) begin
      so.flags_out = {b_n[7], (b_n == 8'd0), b_n[5], k_io[8], b_n[3],
                      ~^({5'd0, k_io[2:0]} ^ b_n), si.data_byte[7], k_io[8]};
    end

    // looping form refetches itself
    if (rep && again) begin
      so.pc_out      = si.pc_in - 16'd2;
      so.memptr_out  = si.pc_in - 16'd1;
      so.repeat_flag = 1'b1;
    end
    return so;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/block_transfer_compare_io_step.sv =====
// Top level of the block transfer / compare / io step unit.
// Depends on btc_io_pkg for beat types and the step function.
//
// Usage: each input beat carries one iteration of a block instruction
// (LDI/LDD/CPI/CPD/INI/IND/OUTI/OUTD and repeating forms) with the
// register values and the byte already read; each output beat carries the
// updated registers, flags, memptr, pc, one optional write and the repeat
// flag. Exactly one output beat per input beat, in order.
// Each beat passes through the input register, then the result register.
// Throughput: one beat per cycle while the receiver keeps m_tready high, set by the single
// combinational step between the two registers.
// Stall: when the receiver holds m_tready low, the result register holds
// and the input register fills; s_tready drops only when both are full.
// Reset (rst, synchronous) empties both registers; no other state exists.
`timescale 1ns / 1ps
`default_nettype none

module block_transfer_compare_io_step (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // acc[7:0] flags_in[15:8] count_bc[31:16] dest_de[47:32] src_hl[63:48]
  // data_byte[71:64] pc_in[87:72] memptr_in[103:88]
  input  wire logic [103:0] s_tdata,
  // req_type[3:0]
  input  wire logic [3:0]   s_tuser,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // flags_out[7:0] count_bc_out[23:8] dest_de_out[39:24] src_hl_out[55:40]
  // memptr_out[71:56] pc_out[87:72] write_address[103:88] write_data[111:104]
  // repeat_flag[112] zero[119:113]
  output logic [119:0]      m_tdata,
  // write_kind[1:0]
  output logic [1:0]        m_tuser
);

  btc_io_pkg::step_in_t  in_reg;
  logic                  in_valid;
  btc_io_pkg::step_out_t res;
  btc_io_pkg::step_out_t out_reg;
  logic                  out_load;

  // result register can take a new value
  assign out_load = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || out_load;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_reg <= '{req_type:  s_tuser,
                  acc:       s_tdata[7:0],
                  flags_in:  s_tdata[15:8],
                  count_bc:  s_tdata[31:16],
                  dest_de:   s_tdata[47:32],
                  src_hl:    s_tdata[63:48],
                  data_byte: s_tdata[71:64],
                  pc_in:     s_tdata[87:72],
                  memptr_in: s_tdata[103:88]};
    end
  end

  // one instruction step
  assign res = btc_io_pkg::block_step(in_reg);

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_reg <= res;
    end
  end

  // pack the result beat
  assign m_tdata = {7'd0, out_reg.repeat_flag, out_reg.write_data, out_reg.write_address,
                    out_reg.pc_out, out_reg.memptr_out, out_reg.src_hl_out,
                    out_reg.dest_de_out, out_reg.count_bc_out, out_reg.flags_out};
  assign m_tuser = out_reg.write_kind;

  // accepted beat lands in the input register
  a_in_fill: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> in_valid)
    else $error("accepted beat not held in input register");

  // a held item moves on when the result side is free
  a_advance: assert property (@(posedge clk) disable iff (rst)
    in_valid && (!m_tvalid || m_tready) |=> m_tvalid)
    else $error("input register did not advance to result register");

  // both registers empty after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid && !in_valid)
    else $error("pipeline not empty after reset");

  // looping result points memptr one past the refetch pc
  a_repeat_mp: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[112] |-> m_tdata[71:56] == m_tdata[87:72] + 16'd1)
    else $error("memptr mismatch on repeat");

  // no write means zero address and data
  a_nowrite_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == btc_io_pkg::WK_NONE |-> m_tdata[111:88] == 24'd0)
    else $error("write fields set without a write");

endmodule

`default_nettype wire

// ===== tb/block_step_checker.sv =====
// Checker for the block transfer / compare / io step unit: watches both
// stream channels, predicts each result beat and compares it field by field.
// Depends on btc_io_pkg for beat types, op codes and flag bit positions.
`timescale 1ns / 1ps

module block_step_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [103:0] s_tdata,
  input  logic [3:0]   s_tuser,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [119:0] m_tdata,
  input  logic [1:0]   m_tuser,
  output int           mismatches,
  output int           outstanding
);

  // predicted result beats, oldest first
  btc_io_pkg::step_out_t pending_results[$];

  // one iteration of a block instruction, as the unit should compute it
  function automatic btc_io_pkg::step_out_t iterate_block(input btc_io_pkg::step_in_t q);
    btc_io_pkg::step_out_t e;
    btc_io_pkg::op_t       op;
    logic        down;
    logic        rep;
    logic        go;
    logic        half;
    logic [15:0] delta;
    logic [15:0] bc_dec;
    logic [7:0]  b_new;
    logic [7:0]  c_adj;
    logic [7:0]  sum_ld;
    logic [7:0]  diff;
    logic [7:0]  diff_adj;
    logic [8:0]  k;
    op    = btc_io_pkg::op_t'(q.req_type[1:0]);
    down  = q.req_type[2];
    rep   = q.req_type[3];
    delta = down ? 16'hffff : 16'h0001;
    bc_dec = q.count_bc - 16'd1;
    b_new  = q.count_bc[15:8] - 8'd1;
    go     = 1'b0;

    e               = '0;
    e.dest_de_out   = q.dest_de;
    e.src_hl_out    = q.src_hl + delta;
    e.memptr_out    = q.memptr_in;
    e.pc_out        = q.pc_in;
    e.write_kind    = btc_io_pkg::WK_NONE;

    case (op)
      // memory to memory copy, sign/zero/carry kept
      btc_io_pkg::OP_LD: begin
        sum_ld          = q.data_byte + q.acc;
        e.count_bc_out  = bc_dec;
        e.dest_de_out   = q.dest_de + delta;
        e.write_kind    = btc_io_pkg::WK_MEM;
        e.write_address = q.dest_de;
        e.write_data    = q.data_byte;
        e.flags_out[btc_io_pkg::FlS]  = q.flags_in[btc_io_pkg::FlS];
        e.flags_out[btc_io_pkg::FlZ]  = q.flags_in[btc_io_pkg::FlZ];
        e.flags_out[btc_io_pkg::FlC]  = q.flags_in[btc_io_pkg::FlC];
        e.flags_out[btc_io_pkg::FlPv] = bc_dec != 16'd0;
        e.flags_out[btc_io_pkg::Fl3]  = sum_ld[3];
        e.flags_out[btc_io_pkg::Fl5]  = sum_ld[1];
        go = bc_dec != 16'd0;
      end
      // compare against A, no write, stops on match
      btc_io_pkg::OP_CP: begin
        diff     = q.acc - q.data_byte;
        half     = q.acc[3:0] < q.data_byte[3:0];
        diff_adj = diff - {7'd0, half};
        e.count_bc_out = bc_dec;
        e.memptr_out   = q.memptr_in + delta;
        e.flags_out[btc_io_pkg::FlS]  = diff[7];
        e.flags_out[btc_io_pkg::FlZ]  = diff == 8'd0;
        e.flags_out[btc_io_pkg::FlH]  = half;
        e.flags_out[btc_io_pkg::FlN]  = 1'b1;
        e.flags_out[btc_io_pkg::FlC]  = q.flags_in[btc_io_pkg::FlC];
        e.flags_out[btc_io_pkg::FlPv] = bc_dec != 16'd0;
        e.flags_out[btc_io_pkg::Fl3]  = diff_adj[3];
        e.flags_out[btc_io_pkg::Fl5]  = diff_adj[1];
        go = (bc_dec != 16'd0) && (diff != 8'd0);
      end
      // port in / port out, B counts
      default: begin
        e.count_bc_out = {b_new, q.count_bc[7:0]};
        if (op == btc_io_pkg::OP_IN) begin
          e.memptr_out    = q.count_bc + delta;
          e.write_kind    = btc_io_pkg::WK_MEM;
          e.write_address = q.src_hl;
          c_adj           = q.count_bc[7:0] + delta[7:0];
        end else begin
          e.memptr_out    = {b_new, q.count_bc[7:0]} + delta;
          e.write_kind    = btc_io_pkg::WK_IO;
          e.write_address = {b_new, q.count_bc[7:0]};
          c_adj           = e.src_hl_out[7:0];
        end
        e.write_data = q.data_byte;
        k = {1'b0, q.data_byte} + {1'b0, c_adj};
        e.flags_out[btc_io_pkg::FlN]  = q.data_byte[7];
        e.flags_out[btc_io_pkg::FlS]  = b_new[7];
        e.flags_out[btc_io_pkg::Fl5]  = b_new[5];
        e.flags_out[btc_io_pkg::Fl3]  = b_new[3];
        e.flags_out[btc_io_pkg::FlZ]  = b_new == 8'd0;
        e.flags_out[btc_io_pkg::FlH]  = k[8];
        e.flags_out[btc_io_pkg::FlC]  = k[8];
        e.flags_out[btc_io_pkg::FlPv] = ~^({5'd0, k[2:0]} ^ b_new);
        go = b_new != 8'd0;
      end
    endcase

    // looping form steps pc back onto its own opcode
    if (rep && go) begin
      e.pc_out      = q.pc_in - 16'd2;
      e.memptr_out  = e.pc_out + 16'd1;
      e.repeat_flag = 1'b1;
    end
    return e;
  endfunction

  // one field compare, reports the first few misses
  task automatic compare_reg(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want) begin
      if (mismatches < 10)
        $display("%0t: %s mismatch, expected %h got %h", $time, name, want, got);
      mismatches = mismatches + 1;
    end
  endtask

  // sample both channels on the clock edge
  always @(posedge clk) begin
    btc_io_pkg::step_in_t  beat_in;
    btc_io_pkg::step_out_t want;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        beat_in.req_type  = s_tuser;
        beat_in.acc       = s_tdata[7:0];
        beat_in.flags_in  = s_tdata[15:8];
        beat_in.count_bc  = s_tdata[31:16];
        beat_in.dest_de   = s_tdata[47:32];
        beat_in.src_hl    = s_tdata[63:48];
        beat_in.data_byte = s_tdata[71:64];
        beat_in.pc_in     = s_tdata[87:72];
        beat_in.memptr_in = s_tdata[103:88];
        pending_results.push_back(iterate_block(beat_in));
      end
      if (m_tvalid && m_tready) begin
        if (pending_results.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: result beat with nothing expected", $time);
          mismatches = mismatches + 1;
        end else begin
          want = pending_results.pop_front();
          compare_reg("flags_out", {8'd0, m_tdata[7:0]}, {8'd0, want.flags_out});
          compare_reg("count_bc_out",  m_tdata[23:8],    want.count_bc_out);
          compare_reg("dest_de_out",   m_tdata[39:24],   want.dest_de_out);
          compare_reg("src_hl_out",    m_tdata[55:40],   want.src_hl_out);
          compare_reg("memptr_out",    m_tdata[71:56],   want.memptr_out);
          compare_reg("pc_out",        m_tdata[87:72],   want.pc_out);
          compare_reg("write_address", m_tdata[103:88],  want.write_address);
          compare_reg("write_data", {8'd0, m_tdata[111:104]}, {8'd0, want.write_data});
          compare_reg("repeat_flag", {15'd0, m_tdata[112]}, {15'd0, want.repeat_flag});
          compare_reg("write_kind", {14'd0, m_tuser}, {14'd0, want.write_kind});
        end
      end
      outstanding <= pending_results.size();
    end
  end

endmodule

// ===== tb/testbench.sv =====
// Top of the step unit testbench: clock, reset, directed and random beats,
// receiver back-pressure, watchdog and verdict.
// Depends on btc_io_pkg, block_transfer_compare_io_step and block_step_checker.
`timescale 1ns / 1ps

module testbench;

  localparam int QuietLimit = 5000;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [103:0] s_tdata = '0;
  logic [3:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [119:0] m_tdata;
  logic [1:0]   m_tuser;
  int           mismatches;
  int           outstanding;
  int           tx_idle_pct = 9;
  int           rx_idle_pct = 76;
  int           quiet = 0;

  always #1 clk = ~clk;

  block_transfer_compare_io_step uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  block_step_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // receiver back-pressure
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // watchdog on cycles with no beat moving
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet <= 0;
    end else if (quiet >= QuietLimit) begin
      $display("[block_transfer_compare_io_step] ERROR");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  function automatic btc_io_pkg::step_in_t make_step(
    input logic [3:0] req, input logic [7:0] a, input logic [7:0] f,
    input logic [15:0] bc, input logic [15:0] de, input logic [15:0] hl,
    input logic [7:0] d, input logic [15:0] pc, input logic [15:0] mp);
    btc_io_pkg::step_in_t q;
    q.req_type  = req;
    q.acc       = a;
    q.flags_in  = f;
    q.count_bc  = bc;
    q.dest_de   = de;
    q.src_hl    = hl;
    q.data_byte = d;
    q.pc_in     = pc;
    q.memptr_in = mp;
    return q;
  endfunction

  // random step, biased toward counters near zero and compare hits
  function automatic btc_io_pkg::step_in_t random_step();
    btc_io_pkg::step_in_t q;
    int       pick;
    q = make_step(4'($urandom_range(15)), 8'($urandom_range(255)),
                  8'($urandom_range(255)), 16'($urandom_range(65535)),
                  16'($urandom_range(65535)), 16'($urandom_range(65535)),
                  8'($urandom_range(255)), 16'($urandom_range(65535)),
                  16'($urandom_range(65535)));
    pick = $urandom_range(9);
    if (pick < 2)
      q.count_bc = 16'($urandom_range(3));
    else if (pick < 4)
      q.count_bc[15:8] = 8'($urandom_range(2));
    if ($urandom_range(5) == 0)
      q.data_byte = q.acc;
    if ($urandom_range(15) == 0)
      q.pc_in = 16'($urandom_range(2));
    return q;
  endfunction

  // present one beat and hold it until accepted
  task automatic send_step(input btc_io_pkg::step_in_t q);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= q.req_type;
    s_tdata  <= {q.memptr_in, q.pc_in, q.data_byte, q.src_hl, q.dest_de,
                 q.count_bc, q.flags_in, q.acc};
    do @(posedge clk); while (!s_tready);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: every form, counter ends, pointer and pc wrap, flag corners
    send_step(make_step(4'd8,  8'hff, 8'hff, 16'h0001, 16'hffff, 16'hffff,
                        8'hff, 16'h0000, 16'h1234));
    send_step(make_step(4'd12, 8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000,
                        8'h00, 16'h0001, 16'hffff));
    send_step(make_step(4'd0,  8'h5a, 8'h3c, 16'h0002, 16'h4000, 16'h8000,
                        8'ha5, 16'h0100, 16'h0000));
    send_step(make_step(4'd4,  8'h01, 8'hc1, 16'h8000, 16'h7fff, 16'h0001,
                        8'h01, 16'hfffe, 16'h5555));
    send_step(make_step(4'd1,  8'h10, 8'h01, 16'h0005, 16'h1111, 16'h2222,
                        8'h01, 16'h3333, 16'h4444));
    send_step(make_step(4'd5,  8'h00, 8'h00, 16'h0001, 16'h0000, 16'h0000,
                        8'hff, 16'h0000, 16'hffff));
    send_step(make_step(4'd9,  8'h42, 8'h00, 16'h0010, 16'h0000, 16'h1000,
                        8'h42, 16'h2000, 16'h0000));
    send_step(make_step(4'd9,  8'h42, 8'hff, 16'h0010, 16'h0000, 16'hffff,
                        8'h41, 16'h2000, 16'h0000));
    send_step(make_step(4'd13, 8'h80, 8'h00, 16'h0001, 16'h0000, 16'h0000,
                        8'h7f, 16'h0002, 16'h0000));
    send_step(make_step(4'd2,  8'h00, 8'h00, 16'h01ff, 16'h0000, 16'hffff,
                        8'h01, 16'h0000, 16'h0000));
    send_step(make_step(4'd6,  8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000,
                        8'hff, 16'h0000, 16'h0000));
    send_step(make_step(4'd10, 8'h00, 8'h00, 16'h0180, 16'h0000, 16'h1234,
                        8'h7f, 16'h0050, 16'h0000));
    send_step(make_step(4'd14, 8'h00, 8'h00, 16'h8012, 16'h0000, 16'h0000,
                        8'h80, 16'h0000, 16'h0000));
    send_step(make_step(4'd3,  8'h00, 8'h00, 16'h0100, 16'h0000, 16'h00ff,
                        8'h00, 16'h0000, 16'h0000));
    send_step(make_step(4'd7,  8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000,
                        8'h80, 16'h0000, 16'h0000));
    send_step(make_step(4'd11, 8'h00, 8'h00, 16'h0200, 16'h0000, 16'h0010,
                        8'hf0, 16'h0001, 16'h0000));
    send_step(make_step(4'd15, 8'h00, 8'h00, 16'h0100, 16'h0000, 16'h0000,
                        8'h01, 16'h0000, 16'h0000));
    send_step(make_step(4'd0,  8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000,
                        8'h00, 16'h0000, 16'h0000));
    send_step(make_step(4'd1,  8'hff, 8'hff, 16'hffff, 16'hffff, 16'hffff,
                        8'h00, 16'hffff, 16'hffff));
    send_step(make_step(4'd3,  8'hff, 8'hff, 16'hffff, 16'hffff, 16'hffff,
                        8'hff, 16'hffff, 16'hffff));

    // random: slow receiver, then slow sender, then full rate
    repeat (650) send_step(random_step());
    tx_idle_pct = 76;
    rx_idle_pct <= 9;
    repeat (650) send_step(random_step());
    tx_idle_pct = 0;
    rx_idle_pct <= 0;
    repeat (650) send_step(random_step());
    s_tvalid <= 1'b0;

    // drain, then wait for stray beats
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("[block_transfer_compare_io_step] OK");
    end else begin
      $display("[block_transfer_compare_io_step] ERROR");
    end
    $finish;
  end

endmodule
